// ===== design/seg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seg_pkg
// Shared types and constants for the segment intersection point core.
// ----------------------------------------------------------------------------
package seg_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_BITS       = 32;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_ENDPT = 2'd1,
        ST_CROSS = 2'd2,
        ST_COLIN = 2'd3
    } t_status;

    // Result fields that bypass the divider lanes.
    typedef struct packed {
        t_status              status;
        logic [OUT_BITS-1:0]  px;
        logic [OUT_BITS-1:0]  py;
    } t_side;

endpackage
`default_nettype wire

// ===== design/seg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seg_front
// Four-stage front end: differences and endpoint match, cross products,
// orientation and determinant sums, then the contact decision.
// ----------------------------------------------------------------------------
module seg_front #(
    parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = seg_pkg::FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_vld,
    input  wire signed [COORD_BITS-1:0]  i_ax0,
    input  wire signed [COORD_BITS-1:0]  i_ay0,
    input  wire signed [COORD_BITS-1:0]  i_ax1,
    input  wire signed [COORD_BITS-1:0]  i_ay1,
    input  wire signed [COORD_BITS-1:0]  i_bx0,
    input  wire signed [COORD_BITS-1:0]  i_by0,
    input  wire signed [COORD_BITS-1:0]  i_bx1,
    input  wire signed [COORD_BITS-1:0]  i_by1,
    output logic                         o_vld,
    output seg_pkg::t_side               o_side,
    output logic signed [COORD_BITS-1:0] o_ax0,
    output logic signed [COORD_BITS-1:0] o_ay0,
    output logic signed [COORD_BITS:0]   o_s1x,
    output logic signed [COORD_BITS:0]   o_s1y,
    output logic signed [2*COORD_BITS+2:0] o_det,
    output logic signed [2*COORD_BITS+2:0] o_num
);
    import seg_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int PW = 2 * C + 2;
    localparam int SW = 2 * C + 3;
    localparam int XW = C + FRAC_BITS + OUT_BITS;

    // Stage 1
    logic                 r1_vld;
    logic signed [C-1:0]  r1_ax0, r1_ay0, r1_epx, r1_epy;
    logic                 r1_ep;
    logic signed [DW-1:0] r1_s1x, r1_s1y, r1_s2x, r1_s2y;
    logic signed [DW-1:0] r1_e1x, r1_e1y, r1_e2x, r1_e2y;
    logic signed [DW-1:0] r1_f0x, r1_f0y, r1_f1x, r1_f1y;
    // Stage 2
    logic                 r2_vld, r2_ep;
    logic signed [C-1:0]  r2_ax0, r2_ay0, r2_epx, r2_epy;
    logic signed [DW-1:0] r2_s1x, r2_s1y;
    logic signed [PW-1:0] r2_p [10];
    // Stage 3
    logic                 r3_vld, r3_ep;
    logic signed [C-1:0]  r3_ax0, r3_ay0, r3_epx, r3_epy;
    logic signed [DW-1:0] r3_s1x, r3_s1y;
    logic signed [SW-1:0] r3_d1, r3_d2, r3_d3, r3_d4, r3_det;

    logic                 bt_up, hit_u, hit_l;
    logic signed [C-1:0]  bux, buy, blx, bly;
    logic                 str_a, str_b;
    t_status              n_status;
    logic signed [XW-1:0] wx, wy;

    function automatic logic straddles(input logic signed [SW-1:0] p,
                                       input logic signed [SW-1:0] q);
        logic pz, qz;
        pz = (p == '0);
        qz = (q == '0);
        return ((!p[SW-1]) && (q[SW-1] || qz)) || ((p[SW-1] || pz) && !q[SW-1]);
    endfunction

    always_comb begin
        bt_up = (i_by0 > i_by1) || ((i_by0 == i_by1) && (i_bx0 > i_bx1));
        bux   = bt_up ? i_bx0 : i_bx1;
        buy   = bt_up ? i_by0 : i_by1;
        blx   = bt_up ? i_bx1 : i_bx0;
        bly   = bt_up ? i_by1 : i_by0;
        hit_u = ((i_ax0 == bux) && (i_ay0 == buy)) || ((i_ax1 == bux) && (i_ay1 == buy));
        hit_l = ((i_ax0 == blx) && (i_ay0 == bly)) || ((i_ax1 == blx) && (i_ay1 == bly));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            o_vld  <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            o_vld  <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ax0 <= i_ax0;
        r1_ay0 <= i_ay0;
        r1_ep  <= hit_u || hit_l;
        r1_epx <= hit_u ? bux : blx;
        r1_epy <= hit_u ? buy : bly;
        r1_s1x <= DW'(i_ax1) - DW'(i_ax0);
        r1_s1y <= DW'(i_ay1) - DW'(i_ay0);
        r1_s2x <= DW'(i_bx1) - DW'(i_bx0);
        r1_s2y <= DW'(i_by1) - DW'(i_by0);
        r1_e1x <= DW'(i_bx0) - DW'(i_ax0);
        r1_e1y <= DW'(i_by0) - DW'(i_ay0);
        r1_e2x <= DW'(i_bx1) - DW'(i_ax0);
        r1_e2y <= DW'(i_by1) - DW'(i_ay0);
        r1_f0x <= DW'(i_ax0) - DW'(i_bx0);
        r1_f0y <= DW'(i_ay0) - DW'(i_by0);
        r1_f1x <= DW'(i_ax1) - DW'(i_bx0);
        r1_f1y <= DW'(i_ay1) - DW'(i_by0);
    end

    always_ff @(posedge i_clk) begin
        r2_ep  <= r1_ep;
        r2_epx <= r1_epx;
        r2_epy <= r1_epy;
        r2_ax0 <= r1_ax0;
        r2_ay0 <= r1_ay0;
        r2_s1x <= r1_s1x;
        r2_s1y <= r1_s1y;
        r2_p[0] <= PW'(r1_s1x * r1_e1y);
        r2_p[1] <= PW'(r1_s1y * r1_e1x);
        r2_p[2] <= PW'(r1_s1x * r1_e2y);
        r2_p[3] <= PW'(r1_s1y * r1_e2x);
        r2_p[4] <= PW'(r1_s2x * r1_f0y);
        r2_p[5] <= PW'(r1_s2y * r1_f0x);
        r2_p[6] <= PW'(r1_s2x * r1_f1y);
        r2_p[7] <= PW'(r1_s2y * r1_f1x);
        r2_p[8] <= PW'(r1_s1x * r1_s2y);
        r2_p[9] <= PW'(r1_s2x * r1_s1y);
    end

    always_ff @(posedge i_clk) begin
        r3_ep  <= r2_ep;
        r3_epx <= r2_epx;
        r3_epy <= r2_epy;
        r3_ax0 <= r2_ax0;
        r3_ay0 <= r2_ay0;
        r3_s1x <= r2_s1x;
        r3_s1y <= r2_s1y;
        r3_d1  <= SW'(r2_p[0]) - SW'(r2_p[1]);
        r3_d2  <= SW'(r2_p[2]) - SW'(r2_p[3]);
        r3_d3  <= SW'(r2_p[4]) - SW'(r2_p[5]);
        r3_d4  <= SW'(r2_p[6]) - SW'(r2_p[7]);
        r3_det <= SW'(r2_p[8]) - SW'(r2_p[9]);
    end

    always_comb begin
        str_a = straddles(r3_d1, r3_d2);
        str_b = straddles(r3_d3, r3_d4);
        if (r3_ep) begin
            n_status = ST_ENDPT;
        end else if (!(str_a && str_b)) begin
            n_status = ST_NONE;
        end else if (r3_det == '0) begin
            n_status = ST_COLIN;
        end else begin
            n_status = ST_CROSS;
        end
        wx = XW'(r3_epx) <<< FRAC_BITS;
        wy = XW'(r3_epy) <<< FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        o_side.status <= n_status;
        o_side.px     <= r3_ep ? wx[OUT_BITS-1:0] : '0;
        o_side.py     <= r3_ep ? wy[OUT_BITS-1:0] : '0;
        o_ax0         <= r3_ax0;
        o_ay0         <= r3_ay0;
        o_s1x         <= r3_s1x;
        o_s1y         <= r3_s1y;
        o_det         <= r3_det;
        // The crossing numerator equals the third orientation value.
        o_num         <= r3_d3;
    end

endmodule
`default_nettype wire

// ===== design/seg_div_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seg_div_lane
// One coordinate lane: forms (base*det + num*dir) << FRAC_BITS and divides
// it by det in a restoring divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module seg_div_lane #(
    parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = seg_pkg::FRAC_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire signed [COORD_BITS-1:0]    i_base,
    input  wire signed [COORD_BITS:0]      i_dir,
    input  wire signed [2*COORD_BITS+2:0]  i_det,
    input  wire signed [2*COORD_BITS+2:0]  i_num,
    output logic [seg_pkg::OUT_BITS-1:0]   o_coord
);
    import seg_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int SW  = 2 * C + 3;
    localparam int BW  = C + SW;
    localparam int MW  = SW + C + 1;
    localparam int NW  = 3 * C + 5;
    localparam int QW  = C + FRAC_BITS + 1;
    localparam int DW  = NW + FRAC_BITS;
    localparam int RW  = DW - QW;
    localparam int EW  = (QW + 1 > OUT_BITS) ? QW + 1 : OUT_BITS;

    logic signed [BW-1:0] r_bd;
    logic signed [MW-1:0] r_nd;
    logic signed [SW-1:0] r_det1, r_det2;
    logic signed [NW-1:0] r_n;

    logic [NW-1:0]        n_mag;
    logic [DW-1:0]        n_div;
    logic [SW-1:0]        n_dmag;

    logic [RW-1:0]        r_rem [QW+1];
    logic [QW-1:0]        r_low [QW+1];
    logic [SW-1:0]        r_dm  [QW+1];
    logic                 r_qn  [QW+1];

    logic signed [EW-1:0] n_q;

    always_ff @(posedge i_clk) begin
        r_bd   <= BW'(i_base * i_det);
        r_nd   <= MW'(i_num * i_dir);
        r_det1 <= i_det;
        r_n    <= NW'(r_bd) + NW'(r_nd);
        r_det2 <= r_det1;
    end

    always_comb begin
        n_mag  = r_n[NW-1] ? NW'(-r_n) : NW'(r_n);
        n_div  = DW'(n_mag) << FRAC_BITS;
        n_dmag = r_det2[SW-1] ? SW'(-r_det2) : SW'(r_det2);
    end

    // For a real crossing the quotient fits in QW bits, so the bits above
    // the quotient field start out as the partial remainder.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_div[DW-1:QW];
        r_low[0] <= n_div[QW-1:0];
        r_dm[0]  <= n_dmag;
        r_qn[0]  <= r_n[NW-1] ^ r_det2[SW-1];
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [RW:0] t;
        logic        ge;
        always_comb begin
            t  = {r_rem[k], r_low[k][QW-1]};
            ge = (t >= {{(RW+1-SW){1'b0}}, r_dm[k]});
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? RW'(t - {{(RW+1-SW){1'b0}}, r_dm[k]}) : t[RW-1:0];
            r_low[k+1] <= {r_low[k][QW-2:0], ge};
            r_dm[k+1]  <= r_dm[k];
            r_qn[k+1]  <= r_qn[k];
        end
    end

    always_comb begin
        n_q = signed'(EW'(r_low[QW]));
        if (r_qn[QW]) begin
            n_q = -n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        o_coord <= n_q[OUT_BITS-1:0];
    end

endmodule
`default_nettype wire

// ===== design/segment_intersection_point_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection_point_core
// Segment pair intersection test with a Q16.16 contact point.
// ----------------------------------------------------------------------------
// A new segment pair is taken on every cycle that start is high; busy is
// always low. The result appears with o_valid for one cycle. The pipeline
// holds four front-end stages and four lane stages beside the restoring
// divider, which resolves one quotient bit per pipeline stage. The receiver
// cannot stall the pipeline and must take each result in the cycle it is
// shown.
module segment_intersection_point_core #(
    parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = seg_pkg::FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire signed [COORD_BITS-1:0]  i_a_start_x,
    input  wire signed [COORD_BITS-1:0]  i_a_start_y,
    input  wire signed [COORD_BITS-1:0]  i_a_end_x,
    input  wire signed [COORD_BITS-1:0]  i_a_end_y,
    input  wire signed [COORD_BITS-1:0]  i_b_start_x,
    input  wire signed [COORD_BITS-1:0]  i_b_start_y,
    input  wire signed [COORD_BITS-1:0]  i_b_end_x,
    input  wire signed [COORD_BITS-1:0]  i_b_end_y,
    output logic                         o_valid,
    output logic [1:0]                   o_hit_status,
    output logic signed [seg_pkg::OUT_BITS-1:0] o_hit_x,
    output logic signed [seg_pkg::OUT_BITS-1:0] o_hit_y
);
    import seg_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int SW  = 2 * C + 3;
    localparam int LAT = C + FRAC_BITS + 5;

    logic                 f_vld;
    t_side                f_side;
    logic signed [C-1:0]  f_ax0, f_ay0;
    logic signed [C:0]    f_s1x, f_s1y;
    logic signed [SW-1:0] f_det, f_num;
    logic [OUT_BITS-1:0]  lane_x, lane_y;

    logic                 r_svld [LAT];
    t_side                r_sdat [LAT];

    assign busy = 1'b0;

    seg_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_ax0   (i_a_start_x),
        .i_ay0   (i_a_start_y),
        .i_ax1   (i_a_end_x),
        .i_ay1   (i_a_end_y),
        .i_bx0   (i_b_start_x),
        .i_by0   (i_b_start_y),
        .i_bx1   (i_b_end_x),
        .i_by1   (i_b_end_y),
        .o_vld   (f_vld),
        .o_side  (f_side),
        .o_ax0   (f_ax0),
        .o_ay0   (f_ay0),
        .o_s1x   (f_s1x),
        .o_s1y   (f_s1y),
        .o_det   (f_det),
        .o_num   (f_num)
    );

    seg_div_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_x (
        .i_clk   (i_clk),
        .i_base  (f_ax0),
        .i_dir   (f_s1x),
        .i_det   (f_det),
        .i_num   (f_num),
        .o_coord (lane_x)
    );

    seg_div_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_y (
        .i_clk   (i_clk),
        .i_base  (f_ay0),
        .i_dir   (f_s1y),
        .i_det   (f_det),
        .i_num   (f_num),
        .o_coord (lane_y)
    );

    // Status and endpoint results ride alongside the divider lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_svld[k] <= 1'b0;
            end
        end else begin
            r_svld[0] <= f_vld;
            for (int k = 1; k < LAT; k++) begin
                r_svld[k] <= r_svld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sdat[0] <= f_side;
        for (int k = 1; k < LAT; k++) begin
            r_sdat[k] <= r_sdat[k-1];
        end
    end

    always_comb begin
        o_valid      = r_svld[LAT-1];
        o_hit_status = r_sdat[LAT-1].status;
        if (r_sdat[LAT-1].status == ST_CROSS) begin
            o_hit_x = lane_x;
            o_hit_y = lane_y;
        end else begin
            o_hit_x = r_sdat[LAT-1].px;
            o_hit_y = r_sdat[LAT-1].py;
        end
    end

endmodule
`default_nettype wire
